// ===== hw/rtl/hatfp_pkg.sv =====
// Shared types, character codes and the character decoder of the time frame parser.
package hatfp_pkg;

    typedef enum logic [3:0] {
        PH_WAIT = 4'd0,
        PH_ID   = 4'd1,
        PH_SEP1 = 4'd2,
        PH_T1   = 4'd3,
        PH_MS1  = 4'd4,
        PH_T2   = 4'd5,
        PH_MS2  = 4'd6,
        PH_SEP2 = 4'd7,
        PH_SUM  = 4'd8,
        PH_END  = 4'd9
    } phase_t;

    typedef enum logic [3:0] {
        ST_NONE    = 4'd0,
        ST_OK      = 4'd1,
        ST_BAD_ID  = 4'd2,
        ST_NO_SEP1 = 4'd3,
        ST_BAD_T1  = 4'd4,
        ST_BAD_MS1 = 4'd5,
        ST_BAD_T2  = 4'd6,
        ST_BAD_MS2 = 4'd7,
        ST_NO_SEP2 = 4'd8,
        ST_BAD_SUM = 4'd9,
        ST_NO_END  = 4'd10
    } status_t;

    localparam logic [7:0] CH_OPEN    = 8'h3C;  // '<'
    localparam logic [7:0] CH_CLOSE   = 8'h3E;  // '>'
    localparam logic [7:0] CH_SEP1    = 8'h21;  // '!'
    localparam logic [7:0] CH_SEP2    = 8'h40;  // '@'
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] ALPHA_OFS  = 8'h37;
    localparam logic [7:0] DIGIT_OFS  = 8'h30;
    localparam logic [7:0] NIBBLE_MAX = 8'h0F;

    localparam int ID_W     = 16;
    localparam int TIME_W   = 32;
    localparam int MILLIS_W = 12;
    localparam int SUM_W    = 32;
    localparam int REC_W    = ID_W + 2 * TIME_W + 2 * MILLIS_W + SUM_W;

    // Packed with the first frame field, the ID, in the lowest bits.
    typedef struct packed {
        logic [SUM_W-1:0]    sum_value;
        logic [MILLIS_W-1:0] millis2_value;
        logic [TIME_W-1:0]   time2_value;
        logic [MILLIS_W-1:0] millis1_value;
        logic [TIME_W-1:0]   time1_value;
        logic [ID_W-1:0]     id_value;
    } record_t;

    typedef struct packed {
        status_t status;
        logic    packet_done;
        record_t rec;
    } result_t;

    // Hex letters and digits map to their value; every other byte passes unchanged.
    function automatic logic [7:0] decode_char(input logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
            c = b - ALPHA_OFS;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            c = b - DIGIT_OFS;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/hatfp_parse_core.sv =====
// Frame parser state, field registers and the per-byte update logic.
module hatfp_parse_core #(
    parameter int ID_DIGITS     = 4,
    parameter int TIME_DIGITS   = 8,
    parameter int MILLIS_DIGITS = 3,
    parameter int SUM_DIGITS    = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         byte_in,
    output hatfp_pkg::result_t res
);

    localparam logic [4:0] ID_DIG     = 5'(ID_DIGITS);
    localparam logic [4:0] TIME_DIG   = 5'(TIME_DIGITS);
    localparam logic [4:0] MILLIS_DIG = 5'(MILLIS_DIGITS);
    localparam logic [4:0] SUM_DIG    = 5'(SUM_DIGITS);

    hatfp_pkg::phase_t  phase_reg, phase_next;
    logic [3:0]         cnt_reg, cnt_next;
    hatfp_pkg::record_t rec_reg, rec_next;
    logic               done_reg, done_next;
    hatfp_pkg::status_t status;

    logic [7:0]  c;
    logic        is_nib;
    logic [31:0] fld_cur;
    logic [31:0] fld_or;
    logic [31:0] fld_new;
    logic [4:0]  dig;
    logic        last;
    logic        take;

    assign c      = hatfp_pkg::decode_char(byte_in);
    assign is_nib = (c <= hatfp_pkg::NIBBLE_MAX);

    // One shared shifter serves whichever field the current phase is filling.
    always_comb begin
        unique case (phase_reg)
            hatfp_pkg::PH_ID:
            begin
                fld_cur = 32'(rec_reg.id_value);
                dig     = ID_DIG;
            end
            hatfp_pkg::PH_T1:
            begin
                fld_cur = rec_reg.time1_value;
                dig     = TIME_DIG;
            end
            hatfp_pkg::PH_MS1:
            begin
                fld_cur = 32'(rec_reg.millis1_value);
                dig     = MILLIS_DIG;
            end
            hatfp_pkg::PH_T2:
            begin
                fld_cur = rec_reg.time2_value;
                dig     = TIME_DIG;
            end
            hatfp_pkg::PH_MS2:
            begin
                fld_cur = 32'(rec_reg.millis2_value);
                dig     = MILLIS_DIG;
            end
            hatfp_pkg::PH_SUM:
            begin
                fld_cur = rec_reg.sum_value;
                dig     = SUM_DIG;
            end
            default:
            begin
                fld_cur = '0;
                dig     = ID_DIG;
            end
        endcase
    end

    assign fld_or  = fld_cur | {28'd0, c[3:0]};
    assign last    = (({1'b0, cnt_reg} + 5'd1) == dig);
    assign fld_new = last ? fld_or : {fld_or[27:0], 4'd0};

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        rec_next   = rec_reg;
        done_next  = done_reg;
        status     = hatfp_pkg::ST_NONE;
        take       = 1'b0;

        unique case (phase_reg)
            hatfp_pkg::PH_ID:
            begin
                if (is_nib) begin
                    take              = 1'b1;
                    rec_next.id_value = fld_new[hatfp_pkg::ID_W-1:0];
                    if (last) phase_next = hatfp_pkg::PH_SEP1;
                end else begin
                    // The partial record stays visible until the next byte.
                    phase_next = hatfp_pkg::PH_WAIT;
                    status     = hatfp_pkg::ST_BAD_ID;
                end
            end
            hatfp_pkg::PH_SEP1:
            begin
                if (c == hatfp_pkg::CH_SEP1) begin
                    phase_next = hatfp_pkg::PH_T1;
                end else begin
                    rec_next   = '0;
                    done_next  = 1'b0;
                    phase_next = hatfp_pkg::PH_WAIT;
                    status     = hatfp_pkg::ST_NO_SEP1;
                end
            end
            hatfp_pkg::PH_T1:
            begin
                if (is_nib) begin
                    take                 = 1'b1;
                    rec_next.time1_value = fld_new;
                    if (last) phase_next = hatfp_pkg::PH_MS1;
                end else begin
                    rec_next   = '0;
                    done_next  = 1'b0;
                    phase_next = hatfp_pkg::PH_WAIT;
                    status     = hatfp_pkg::ST_BAD_T1;
                end
            end
            hatfp_pkg::PH_MS1:
            begin
                if (is_nib) begin
                    take                   = 1'b1;
                    rec_next.millis1_value = fld_new[hatfp_pkg::MILLIS_W-1:0];
                    if (last) phase_next = hatfp_pkg::PH_T2;
                end else begin
                    rec_next   = '0;
                    done_next  = 1'b0;
                    phase_next = hatfp_pkg::PH_WAIT;
                    status     = hatfp_pkg::ST_BAD_MS1;
                end
            end
            hatfp_pkg::PH_T2:
            begin
                if (is_nib) begin
                    take                 = 1'b1;
                    rec_next.time2_value = fld_new;
                    if (last) phase_next = hatfp_pkg::PH_MS2;
                end else begin
                    rec_next   = '0;
                    done_next  = 1'b0;
                    phase_next = hatfp_pkg::PH_WAIT;
                    status     = hatfp_pkg::ST_BAD_T2;
                end
            end
            hatfp_pkg::PH_MS2:
            begin
                if (is_nib) begin
                    take                   = 1'b1;
                    rec_next.millis2_value = fld_new[hatfp_pkg::MILLIS_W-1:0];
                    if (last) phase_next = hatfp_pkg::PH_SEP2;
                end else begin
                    rec_next   = '0;
                    done_next  = 1'b0;
                    phase_next = hatfp_pkg::PH_WAIT;
                    status     = hatfp_pkg::ST_BAD_MS2;
                end
            end
            hatfp_pkg::PH_SEP2:
            begin
                if (c == hatfp_pkg::CH_SEP2) begin
                    phase_next = hatfp_pkg::PH_SUM;
                end else begin
                    rec_next   = '0;
                    done_next  = 1'b0;
                    phase_next = hatfp_pkg::PH_WAIT;
                    status     = hatfp_pkg::ST_NO_SEP2;
                end
            end
            hatfp_pkg::PH_SUM:
            begin
                if (is_nib) begin
                    take               = 1'b1;
                    rec_next.sum_value = fld_new;
                    if (last) phase_next = hatfp_pkg::PH_END;
                end else begin
                    rec_next   = '0;
                    done_next  = 1'b0;
                    phase_next = hatfp_pkg::PH_WAIT;
                    status     = hatfp_pkg::ST_BAD_SUM;
                end
            end
            hatfp_pkg::PH_END:
            begin
                if (c == hatfp_pkg::CH_CLOSE) begin
                    done_next = 1'b1;
                    status    = hatfp_pkg::ST_OK;
                end else begin
                    rec_next  = '0;
                    done_next = 1'b0;
                    status    = hatfp_pkg::ST_NO_END;
                end
                phase_next = hatfp_pkg::PH_WAIT;
            end
            default:
            begin
                // Waiting, and any unused phase code: every byte clears the record.
                rec_next   = '0;
                done_next  = 1'b0;
                cnt_next   = '0;
                phase_next = (c == hatfp_pkg::CH_OPEN) ? hatfp_pkg::PH_ID
                                                       : hatfp_pkg::PH_WAIT;
            end
        endcase

        if (take) begin
            cnt_next = last ? 4'd0 : cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= hatfp_pkg::PH_WAIT;
            cnt_reg   <= '0;
            rec_reg   <= '0;
            done_reg  <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            rec_reg   <= rec_next;
            done_reg  <= done_next;
        end
    end

    assign res.status      = status;
    assign res.packet_done = done_next;
    assign res.rec         = rec_next;

endmodule

// ===== hw/rtl/hex_ascii_time_frame_parser.sv =====
// Top level of the hex ASCII time frame parser: input register, parser core, result register.
// The block takes one received byte per item and returns one result item per byte, in order.
// It parses the frame '<' ID '!' T1 MS1 T2 MS2 '@' SUM '>' of upper-case hex digits (raw byte
// values 0 to 15 also count as digits) and reports a status code, the frame-done flag and the
// current record with every result. A byte is held in the input register and moves on into the
// result register once that register is free or being read, and a new byte is taken every cycle
// while the downstream side keeps taking results; the single parser state update between the two
// registers sets that rate. The checksum field is captured but not verified.
module hex_ascii_time_frame_parser #(
    parameter int ID_DIGITS     = 4,
    parameter int TIME_DIGITS   = 8,
    parameter int MILLIS_DIGITS = 3,
    parameter int SUM_DIGITS    = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // rx_byte[7:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // id_value[15:0], time1_value[47:16], millis1_value[59:48],
    // time2_value[91:60], millis2_value[103:92], sum_value[135:104]
    output logic [hatfp_pkg::REC_W-1:0] m_tdata,
    output logic                        m_tlast,   // packet_done
    output logic [3:0]                  m_tuser    // status[3:0]
);

    logic                in_vld_reg;
    logic [7:0]          in_byte_reg;
    logic                out_vld_reg;
    hatfp_pkg::result_t  out_res_reg;
    hatfp_pkg::result_t  res;
    logic                advance;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    hatfp_parse_core #(
        .ID_DIGITS     (ID_DIGITS),
        .TIME_DIGITS   (TIME_DIGITS),
        .MILLIS_DIGITS (MILLIS_DIGITS),
        .SUM_DIGITS    (SUM_DIGITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (in_byte_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_res_reg.rec;
    assign m_tlast  = out_res_reg.packet_done;
    assign m_tuser  = out_res_reg.status;

endmodule

// ===== hw/rtl/hatfp_checker.sv =====
// Port-level checks of the time frame parser and their binding to the top level.
module hatfp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [hatfp_pkg::REC_W-1:0] m_tdata,
    input logic                        m_tlast,
    input logic [3:0]                  m_tuser
);

    // A finished frame is reported only together with the parsed_ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == hatfp_pkg::ST_OK)
    else $error("packet_done without parsed_ok");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == hatfp_pkg::ST_OK |-> m_tlast)
    else $error("parsed_ok without packet_done");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= hatfp_pkg::ST_NO_END)
    else $error("status code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // An empty result register never holds back the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("input stalled with an empty result register");

endmodule

bind hex_ascii_time_frame_parser hatfp_checker u_hatfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
